// File: rtl/jfc_pkg.sv
`default_nettype none

package jfc_pkg;

    localparam int MAX_SLOTS       = 4;
    localparam int MAX_FRAME_BYTES = 65536;

    localparam int SLOT_W     = 2;
    localparam int SLOT_CNT_W = 3;
    localparam int OFFSET_W   = 16;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [BYTE_W-1:0] MARK_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] SOI_BYTE  = 8'hD8;
    localparam logic [BYTE_W-1:0] EOI_BYTE  = 8'hD9;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE   = 2'd1;

    localparam logic [LEN_W-1:0]      CAPACITY_RESET = 17'd10240;
    localparam logic [SLOT_CNT_W-1:0] SLOTS_RESET    = 3'd2;
    localparam logic [LEN_W-1:0]      CAPACITY_MIN   = 17'd2;
    localparam logic [LEN_W-1:0]      CAPACITY_MAX   = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [SLOT_CNT_W-1:0] SLOTS_MIN      = 3'd1;
    localparam logic [SLOT_CNT_W-1:0] SLOTS_MAX      = SLOT_CNT_W'(MAX_SLOTS);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic              is_release;
        logic [SLOT_W-1:0] rel_slot;
        logic [BYTE_W-1:0] c0;
        logic              soi;
        logic              eoi;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] offset;
        logic [BYTE_W-1:0]   data;
        logic                frame_done;
        logic [LEN_W-1:0]    frame_length;
        logic                last;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/jfc_front.sv
`default_nettype none

module jfc_front (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire                        action,
    input  wire  [7:0]                 byte_value,
    input  wire  [1:0]                 release_slot,
    input  wire                        q_ready,
    output logic                       q_push,
    output jfc_pkg::cmd_t              q_cmd
);
    import jfc_pkg::*;

    logic [BYTE_W-1:0] held_byte_reg;
    logic [BYTE_W-1:0] held_byte_next;
    logic              held_valid_reg;
    logic              held_valid_next;
    logic              accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        q_push          = 1'b0;
        q_cmd.is_release = action;
        q_cmd.rel_slot   = release_slot;
        q_cmd.c0         = held_byte_reg;
        q_cmd.soi        = (held_byte_reg == MARK_BYTE) && (byte_value == SOI_BYTE);
        q_cmd.eoi        = (held_byte_reg == MARK_BYTE) && (byte_value == EOI_BYTE);
        if (accept)
        begin
            if (action)
            begin
                q_push = 1'b1;
            end
            else
            begin
                q_push          = held_valid_reg;
                held_byte_next  = byte_value;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/jfc_cmd_queue.sv
`default_nettype none

module jfc_cmd_queue (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        push,
    input  jfc_pkg::cmd_t              push_cmd,
    output logic                       push_ready,
    input  wire                        pop,
    output logic                       pop_valid,
    output jfc_pkg::cmd_t              pop_cmd
);
    import jfc_pkg::*;

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != CMD_CNT_W'(CMD_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/jfc_back.sv
`default_nettype none

module jfc_back (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [jfc_pkg::LEN_W-1:0]        eff_capacity,
    input  wire  [jfc_pkg::SLOT_CNT_W-1:0]   eff_slots,
    input  wire                              cmd_valid,
    input  jfc_pkg::cmd_t                    cmd,
    output logic                             cmd_pop,
    input  wire                              space_ok,
    output logic                             push0,
    output logic                             push1,
    output jfc_pkg::res_t                    res0,
    output jfc_pkg::res_t                    res1
);
    import jfc_pkg::*;

    logic                 capturing_reg;
    logic                 capturing_next;
    logic [LEN_W-1:0]     count_reg;
    logic [LEN_W-1:0]     count_next;
    logic [SLOT_W-1:0]    active_reg;
    logic [SLOT_W-1:0]    active_next;
    logic [MAX_SLOTS-1:0] free_reg;
    logic [MAX_SLOTS-1:0] free_next;
    logic [SLOT_W-1:0]    found_slot;
    logic                 found;
    logic [LEN_W-1:0]     off_plus1;
    logic [LEN_W-1:0]     off_plus2;

    assign cmd_pop   = cmd_valid && space_ok;
    assign off_plus1 = count_reg + 1'b1;
    assign off_plus2 = count_reg + 2'd2;

    always_comb
    begin
        found      = 1'b0;
        found_slot = '0;
        for (int y = 0; y < MAX_SLOTS; y++)
        begin
            if ((SLOT_CNT_W'(y) < eff_slots) && free_reg[y])
            begin
                found      = 1'b1;
                found_slot = SLOT_W'(y);
            end
        end
    end

    always_comb
    begin
        capturing_next = capturing_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        free_next      = free_reg;
        push0          = 1'b0;
        push1          = 1'b0;
        res0.slot         = active_reg;
        res0.offset       = count_reg[OFFSET_W-1:0];
        res0.data         = cmd.c0;
        res0.frame_done   = 1'b0;
        res0.frame_length = '0;
        res0.last         = 1'b1;
        res1.slot         = active_reg;
        res1.offset       = off_plus1[OFFSET_W-1:0];
        res1.data         = EOI_BYTE;
        res1.frame_done   = 1'b1;
        res1.frame_length = off_plus2;
        res1.last         = 1'b1;
        if (cmd_pop)
        begin
            if (cmd.is_release)
            begin
                if ({1'b0, cmd.rel_slot} < eff_slots)
                begin
                    free_next[cmd.rel_slot] = 1'b1;
                end
            end
            else if (!capturing_reg)
            begin
                if (cmd.soi && found)
                begin
                    capturing_next = 1'b1;
                    active_next    = found_slot;
                    count_next     = LEN_W'(1);
                    push0          = 1'b1;
                    res0.slot      = found_slot;
                    res0.offset    = '0;
                end
            end
            else if (count_reg >= eff_capacity - 1'b1)
            begin
                capturing_next = 1'b0;
            end
            else if (cmd.eoi)
            begin
                push0                 = 1'b1;
                push1                 = 1'b1;
                res0.last             = 1'b0;
                count_next            = off_plus2;
                free_next[active_reg] = 1'b0;
                capturing_next        = 1'b0;
            end
            else if (cmd.soi)
            begin
                push0           = 1'b1;
                push1           = 1'b1;
                res0.last       = 1'b0;
                res1.offset     = '0;
                res1.data       = cmd.c0;
                res1.frame_done = 1'b0;
                res1.frame_length = '0;
                count_next      = LEN_W'(1);
            end
            else
            begin
                push0      = 1'b1;
                count_next = off_plus1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            count_reg     <= '0;
            active_reg    <= '0;
            free_reg      <= '1;
        end
        else
        begin
            capturing_reg <= capturing_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            free_reg      <= free_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/jfc_out_queue.sv
`default_nettype none

module jfc_out_queue (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        push0,
    input  wire                        push1,
    input  jfc_pkg::res_t              res0,
    input  jfc_pkg::res_t              res1,
    output logic                       space_ok,
    output logic                       out_valid,
    input  wire                        out_ready,
    output jfc_pkg::res_t              out_res
);
    import jfc_pkg::*;

    res_t                 entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [OUT_CNT_W-1:0] count_next;
    logic [OUT_PTR_W-1:0] wr_ptr_second;
    logic                 do_pop;
    logic [1:0]           push_cnt;

    assign space_ok      = (count_reg <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign out_valid     = (count_reg != '0);
    assign out_res       = entry_reg[rd_ptr_reg];
    assign do_pop        = out_valid && out_ready;
    assign wr_ptr_second = wr_ptr_reg + 1'b1;
    assign push_cnt      = {1'b0, push0} + {1'b0, push1};

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push_cnt);
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(push_cnt) - OUT_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            entry_reg[wr_ptr_reg] <= res0;
        end
        if (push1)
        begin
            entry_reg[wr_ptr_second] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/jpeg_frame_capture.sv
// A result is registered in the command queue, then in the output queue, before it leaves the block.
// Releases and the first byte after reset give no result.
// Throughput: one input per cycle when in_ready; one output per cycle leaves when out_ready is high.
// A pair that closes or restarts a frame gives two results, which leave one after the other.
// The output queue holds four results; the front stalls only when the command queue is full.
// Reset: asynchronous, active low; clears pairing, capture state and queues, frees every slot.
`default_nettype none

module jpeg_frame_capture (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 action,
    input  wire  [7:0]                          byte_value,
    input  wire  [1:0]                          release_slot,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [1:0]                          slot,
    output logic [15:0]                         offset,
    output logic [7:0]                          data,
    output logic                                frame_done,
    output logic [16:0]                         frame_length,
    output logic                                last,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [jfc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [jfc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import jfc_pkg::*;

    logic [LEN_W-1:0]      capacity_reg;
    logic [LEN_W-1:0]      capacity_next;
    logic [SLOT_CNT_W-1:0] slots_reg;
    logic [SLOT_CNT_W-1:0] slots_next;
    logic [LEN_W-1:0]      eff_capacity;
    logic [SLOT_CNT_W-1:0] eff_slots;

    logic q_ready;
    logic q_push;
    cmd_t q_cmd;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic space_ok;
    logic push0;
    logic push1;
    res_t res0;
    res_t res1;
    res_t out_res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        capacity_next = capacity_reg;
        slots_next    = slots_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_CAPACITY: capacity_next = cfg_data[LEN_W-1:0];
                REG_SLOTS_IN_USE:   slots_next    = cfg_data[SLOT_CNT_W-1:0];
                default:
                begin
                    capacity_next = capacity_reg;
                    slots_next    = slots_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            slots_reg    <= SLOTS_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
            slots_reg    <= slots_next;
        end
    end

    assign eff_capacity = (capacity_reg < CAPACITY_MIN) ? CAPACITY_MIN :
                          (capacity_reg > CAPACITY_MAX) ? CAPACITY_MAX : capacity_reg;
    assign eff_slots    = (slots_reg < SLOTS_MIN) ? SLOTS_MIN :
                          (slots_reg > SLOTS_MAX) ? SLOTS_MAX : slots_reg;

    jfc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .byte_value   (byte_value),
        .release_slot (release_slot),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    jfc_cmd_queue u_cmd_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_ready (q_ready),
        .pop        (cmd_pop),
        .pop_valid  (cmd_valid),
        .pop_cmd    (cmd)
    );

    jfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .eff_capacity (eff_capacity),
        .eff_slots    (eff_slots),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .space_ok     (space_ok),
        .push0        (push0),
        .push1        (push1),
        .res0         (res0),
        .res1         (res1)
    );

    jfc_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (push0),
        .push1     (push1),
        .res0      (res0),
        .res1      (res1),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign slot         = out_res.slot;
    assign offset       = out_res.offset;
    assign data         = out_res.data;
    assign frame_done   = out_res.frame_done;
    assign frame_length = out_res.frame_length;
    assign last         = out_res.last;

endmodule

`default_nettype wire

// File: dv/tb_jpeg_frame_capture.sv
`default_nettype none

import jfc_pkg::*;

localparam logic ACT_BYTE    = 1'b0;
localparam logic ACT_RELEASE = 1'b1;

// Tracks the capture state and keeps the byte writes that are still owed.
class capture_scoreboard;

    logic [LEN_W-1:0]      capacity_reg;
    logic [SLOT_CNT_W-1:0] slots_reg;
    logic                  capturing;
    logic [BYTE_W-1:0]     held_byte;
    logic                  held_valid;
    int                    write_count;
    int                    active_slot;
    logic                  slot_free [MAX_SLOTS];
    res_t                  owed_writes [$];
    int                    errors;

    function new();
        capacity_reg = CAPACITY_RESET;
        slots_reg    = SLOTS_RESET;
        capturing    = 1'b0;
        held_byte    = '0;
        held_valid   = 1'b0;
        write_count  = 0;
        active_slot  = 0;
        errors       = 0;
        foreach (slot_free[i])
        begin
            slot_free[i] = 1'b1;
        end
    endfunction

    function int live_capacity();
        int c;
        c = int'(capacity_reg);
        if (c < int'(CAPACITY_MIN))
            c = int'(CAPACITY_MIN);
        if (c > int'(CAPACITY_MAX))
            c = int'(CAPACITY_MAX);
        return c;
    endfunction

    function int live_slots();
        int s;
        s = int'(slots_reg);
        if (s < int'(SLOTS_MIN))
            s = int'(SLOTS_MIN);
        if (s > int'(SLOTS_MAX))
            s = int'(SLOTS_MAX);
        return s;
    endfunction

    function int pending();
        return owed_writes.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        if (idx == REG_FRAME_CAPACITY)
            capacity_reg = value[LEN_W-1:0];
        else if (idx == REG_SLOTS_IN_USE)
            slots_reg = value[SLOT_CNT_W-1:0];
    endfunction

    function void owe_write(int off, logic [BYTE_W-1:0] value, logic done, int flen,
                            logic fin);
        res_t w;
        w.slot         = SLOT_W'(active_slot);
        w.offset       = OFFSET_W'(off);
        w.data         = value;
        w.frame_done   = done;
        w.frame_length = LEN_W'(flen);
        w.last         = fin;
        owed_writes.push_back(w);
    endfunction

    function void note_input(logic act, logic [BYTE_W-1:0] b, logic [SLOT_W-1:0] r);
        logic [BYTE_W-1:0] first;
        int found;
        int off;
        int y;
        if (act == ACT_RELEASE)
        begin
            if (int'(r) < live_slots())
                slot_free[r] = 1'b1;
            return;
        end
        if (!held_valid)
        begin
            held_byte  = b;
            held_valid = 1'b1;
            return;
        end
        first     = held_byte;
        held_byte = b;
        if (!capturing)
        begin
            if (first != MARK_BYTE || b != SOI_BYTE)
                return;
            found = -1;
            for (y = 0; y < live_slots(); y++)
            begin
                if (slot_free[y])
                    found = y;
            end
            if (found < 0)
                return;
            capturing   = 1'b1;
            active_slot = found;
            write_count = 1;
            owe_write(0, first, 1'b0, 0, 1'b1);
            return;
        end
        if (write_count >= live_capacity() - 1)
        begin
            capturing = 1'b0;
            return;
        end
        off         = write_count;
        write_count = off + 1;
        if (first == MARK_BYTE && b == EOI_BYTE)
        begin
            owe_write(off, first, 1'b0, 0, 1'b0);
            owe_write(off + 1, b, 1'b1, off + 2, 1'b1);
            write_count            = off + 2;
            slot_free[active_slot] = 1'b0;
            capturing              = 1'b0;
        end
        else if (first == MARK_BYTE && b == SOI_BYTE)
        begin
            owe_write(off, first, 1'b0, 0, 1'b0);
            owe_write(0, first, 1'b0, 0, 1'b1);
            write_count = 1;
        end
        else
        begin
            owe_write(off, first, 1'b0, 0, 1'b1);
        end
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want, res_t w);
        if (got !== want)
            report($sformatf("slot %0d offset %0d: %s is %0d, expected %0d",
                             w.slot, w.offset, name, got, want));
    endtask

    task check_result(res_t got);
        res_t want;
        if (owed_writes.size() == 0)
        begin
            report($sformatf("unexpected write slot %0d offset %0d data %02h",
                             got.slot, got.offset, got.data));
            return;
        end
        want = owed_writes.pop_front();
        check_field("slot", 64'(got.slot), 64'(want.slot), want);
        check_field("offset", 64'(got.offset), 64'(want.offset), want);
        check_field("data", 64'(got.data), 64'(want.data), want);
        check_field("frame_done", 64'(got.frame_done), 64'(want.frame_done), want);
        check_field("frame_length", 64'(got.frame_length), 64'(want.frame_length), want);
        check_field("last", 64'(got.last), 64'(want.last), want);
    endtask

endclass

module tb_jpeg_frame_capture;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  action = ACT_BYTE;
    logic [7:0]            byte_value = '0;
    logic [1:0]            release_slot = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            slot;
    logic [15:0]           offset;
    logic [7:0]            data;
    logic                  frame_done;
    logic [16:0]           frame_length;
    logic                  last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    capture_scoreboard sb = new();

    int send_gap_max = 0;
    int recv_gap_max = 0;
    int hold_off_cycles = 0;

    jpeg_frame_capture u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .byte_value   (byte_value),
        .release_slot (release_slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .slot         (slot),
        .offset       (offset),
        .data         (data),
        .frame_done   (frame_done),
        .frame_length (frame_length),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic send_item(input logic act, input logic [7:0] b, input logic [1:0] r);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        byte_value   <= b;
        release_slot <= r;
        do @(posedge clk); while (!in_ready);
        sb.note_input(act, b, r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(ACT_BYTE, b, 2'($urandom_range(0, 3)));
    endtask

    task automatic send_release(input logic [1:0] r);
        send_item(ACT_RELEASE, 8'($urandom_range(0, 255)), r);
    endtask

    task automatic pause_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task automatic reconfigure(input logic [16:0] cap, input logic [2:0] slots);
        pause_for_results();
        repeat (12) @(posedge clk);
        write_reg(REG_FRAME_CAPACITY, cap);
        write_reg(REG_SLOTS_IN_USE, CFG_DATA_W'(slots));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input int body_max, inout int sent);
        int len;
        int k;
        int i;
        k = $urandom_range(0, 15);
        if (k == 0)
        begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        if (k < 8)
        begin
            send_release(2'($urandom_range(0, 3)));
            sent++;
        end
        if ($urandom_range(0, 19) == 0)
            pause_for_results();
        send_byte(MARK_BYTE);
        send_byte(SOI_BYTE);
        sent += 2;
        len = $urandom_range(0, body_max);
        for (i = 0; i < len; i++)
        begin
            k = $urandom_range(0, 31);
            if (k == 0)
            begin
                send_byte(MARK_BYTE);
                send_byte(SOI_BYTE);
                sent++;
            end
            else if (k == 1)
                send_release(2'($urandom_range(0, 3)));
            else if (k == 2)
                send_byte(MARK_BYTE);
            else
                send_byte(8'($urandom_range(0, 255)));
            sent++;
        end
        if ($urandom_range(0, 7) != 0)
        begin
            send_byte(MARK_BYTE);
            send_byte(EOI_BYTE);
            sent += 2;
        end
    endtask

    task automatic run_phase(input logic [16:0] cap, input logic [2:0] slots,
                             input int sgap, input int rgap, input int hold,
                             input int items, input int body_max);
        int sent;
        reconfigure(cap, slots);
        send_gap_max    = sgap;
        recv_gap_max    = rgap;
        hold_off_cycles = hold;
        sent = 0;
        while (sent < items)
            send_frame(body_max, sent);
    endtask

    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            n = $urandom_range(0, recv_gap_max);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result('{slot, offset, data, frame_done, frame_length, last});
        end
    end

    initial
    begin
        int waited;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_max = 3;
        recv_gap_max = 3;
        send_byte(8'h00);
        send_byte(MARK_BYTE);
        send_byte(SOI_BYTE);
        send_byte(8'h7F);
        send_byte(MARK_BYTE);
        send_byte(SOI_BYTE);
        send_byte(8'h80);
        send_release(2'd3);
        send_byte(MARK_BYTE);
        send_byte(EOI_BYTE);
        send_byte(MARK_BYTE);
        send_byte(SOI_BYTE);
        send_release(2'd0);
        send_byte(MARK_BYTE);
        send_byte(EOI_BYTE);
        send_byte(MARK_BYTE);
        send_byte(SOI_BYTE);
        send_release(2'd1);
        send_release(2'd0);
        send_byte(MARK_BYTE);
        send_byte(SOI_BYTE);
        send_byte(8'h01);
        send_byte(MARK_BYTE);
        send_byte(EOI_BYTE);
        send_release(2'd1);

        run_phase(17'd0, 3'd0, 10, 10, 0, 50, 4);
        run_phase(17'd3, 3'd1, 0, 0, 0, 60, 5);
        run_phase(17'd17, 3'd3, 10, 0, 0, 80, 20);
        run_phase(17'd40, 3'd4, 0, 10, 0, 80, 45);
        run_phase(17'd131071, 3'd7, 10, 10, 0, 70, 30);
        run_phase(17'd65536, 3'd4, 0, 0, 300, 80, 30);
        run_phase(17'd1, 3'd5, 3, 3, 0, 50, 3);
        run_phase(17'd10240, 3'd2, 10, 10, 0, 70, 25);
        run_phase(17'd2, 3'd4, 0, 0, 0, 60, 4);

        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (sb.pending() != 0 && waited < 50000);
        repeat (12) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected writes never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("[jpeg_frame_capture] OK");
        else
            $display("[jpeg_frame_capture] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[jpeg_frame_capture] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/jfc_pkg.sv
rtl/jfc_front.sv
rtl/jfc_cmd_queue.sv
rtl/jfc_back.sv
rtl/jfc_out_queue.sv
rtl/jpeg_frame_capture.sv
dv/tb_jpeg_frame_capture.sv
